// ===== hdl/modexp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package modexp_pkg;

	// sequencer states of the square and multiply loop
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_BIT,
		ST_MUL,
		ST_SQR,
		ST_DONE
	} modexp_state_t;

	// controls decoded from the state for the shared multiply-reduce unit
	typedef struct packed {
		logic run;      // unit takes one multiplier bit this cycle
		logic b_one;    // multiplicand is the constant one (base reduction)
		logic busy;
		logic done;
	} modexp_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/modular_exponentiation.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  | ports                              | beat marked by
// ---------+------------------------------------+--------------------------
// command  | base_value, power                  | start high while busy low
// result   | residue                            | done high for one cycle
// config   | modulus_wdata                      | modulus_we high
//
// One shared bit-serial multiply-reduce unit (shift, add, reduce by m or 2m)
// takes one multiplier bit per cycle. An item with a modulus of two or more
// first reduces the base, then runs a multiply for each set power bit and a
// square for every power bit. A modulus below two gives 0 and skips the loop.
// Reset clears the sequencer and sets the modulus to 2. busy stays high until
// the done beat; the receiver cannot stall.
module modular_exponentiation
	import modexp_pkg::*;
#(
	parameter int OPERAND_WIDTH = 31
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [OPERAND_WIDTH-1:0] base_value,
	input  wire logic [OPERAND_WIDTH-1:0] power,
	output logic                          busy,
	output logic                          done,
	output logic [OPERAND_WIDTH-1:0]      residue,
	input  wire logic                     modulus_we,
	input  wire logic [OPERAND_WIDTH-1:0] modulus_wdata
);

	localparam int W  = OPERAND_WIDTH;
	localparam int XW = OPERAND_WIDTH + 2;
	localparam int CW = (OPERAND_WIDTH > 1) ? $clog2(OPERAND_WIDTH) : 1;
	localparam logic [CW-1:0] LAST = CW'(OPERAND_WIDTH - 1);

	modexp_state_t state_q, state_d;
	modexp_ctrl_t  ctrl;

	logic [W-1:0]  m_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  sq_q;
	logic [W-1:0]  exp_q;
	logic [W-1:0]  opa_q;
	logic [W-1:0]  r_q;
	logic [CW-1:0] step_q;
	logic [CW-1:0] bit_q;

	logic [W-1:0]  mul_b;
	logic [XW-1:0] sum;
	logic [XW-1:0] m1;
	logic [XW-1:0] m2;
	logic [W-1:0]  red;
	logic          step_last;
	logic          small_mod;

	assign step_last = (step_q == LAST);
	assign small_mod = (m_q < W'(2));

	// modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q <= W'(2);
		end else if (modulus_we) begin
			m_q <= modulus_wdata;
		end
	end

	// shared multiply-reduce step: r = (2r + bit*b) mod m, with r < m kept
	always_comb begin
		mul_b = ctrl.b_one ? W'(1) : sq_q;
		m1    = {2'b00, m_q};
		m2    = {1'b0, m_q, 1'b0};
		sum   = {1'b0, r_q, 1'b0} + (opa_q[W-1] ? {2'b00, mul_b} : '0);
		if (sum >= m2) begin
			red = W'(sum - m2);
		end else if (sum >= m1) begin
			red = W'(sum - m1);
		end else begin
			red = sum[W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = small_mod ? ST_DONE : ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (step_last) begin
					state_d = ST_BIT;
				end
			end
			ST_BIT: begin
				state_d = exp_q[0] ? ST_MUL : ST_SQR;
			end
			ST_MUL: begin
				if (step_last) begin
					state_d = ST_SQR;
				end
			end
			ST_SQR: begin
				if (step_last) begin
					state_d = (bit_q == LAST) ? ST_DONE : ST_BIT;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		ctrl = '0;
		unique case (state_q)
			ST_IDLE: begin
				ctrl.busy = 1'b0;
			end
			ST_REDUCE: begin
				ctrl.busy  = 1'b1;
				ctrl.run   = 1'b1;
				ctrl.b_one = 1'b1;
			end
			ST_BIT: begin
				ctrl.busy = 1'b1;
			end
			ST_MUL, ST_SQR: begin
				ctrl.busy = 1'b1;
				ctrl.run  = 1'b1;
			end
			ST_DONE: begin
				ctrl.busy = 1'b1;
				ctrl.done = 1'b1;
			end
			default: begin
				ctrl = '0;
			end
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// exponent bit counter and unit step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			bit_q  <= '0;
		end else begin
			if (state_q == ST_IDLE) begin
				step_q <= '0;
				bit_q  <= '0;
			end else if (ctrl.run) begin
				step_q <= step_last ? '0 : step_q + CW'(1);
			end
			if (state_q == ST_SQR && step_last) begin
				bit_q <= bit_q + CW'(1);
			end
		end
	end

	// operand and result registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					opa_q <= base_value;
					exp_q <= power;
					r_q   <= '0;
					acc_q <= small_mod ? '0 : W'(1);
				end
			end
			ST_REDUCE: begin
				opa_q <= {opa_q[W-2:0], 1'b0};
				r_q   <= red;
				if (step_last) begin
					sq_q <= red;
				end
			end
			ST_BIT: begin
				opa_q <= exp_q[0] ? acc_q : sq_q;
				r_q   <= '0;
			end
			ST_MUL: begin
				// last step hands the square over as the next multiplier
				if (step_last) begin
					acc_q <= red;
					opa_q <= sq_q;
					r_q   <= '0;
				end else begin
					opa_q <= {opa_q[W-2:0], 1'b0};
					r_q   <= red;
				end
			end
			ST_SQR: begin
				opa_q <= {opa_q[W-2:0], 1'b0};
				r_q   <= red;
				if (step_last) begin
					sq_q  <= red;
					exp_q <= {1'b0, exp_q[W-1:1]};
				end
			end
			ST_DONE: begin
				r_q <= '0;
			end
			default: begin
				r_q <= '0;
			end
		endcase
	end

	assign busy    = ctrl.busy;
	assign done    = ctrl.done;
	assign residue = acc_q;

endmodule

`default_nettype wire

// ===== hdl/modexp_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module modexp_chk #(
	parameter int OPERAND_WIDTH = 31
) (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     start,
	input wire logic                     busy,
	input wire logic                     done,
	input wire logic [OPERAND_WIDTH-1:0] residue
);

	// a start beat taken while idle makes the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("start beat not taken");

	// a result beat only ends a busy period
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done while idle");

	// the result beat lasts one cycle and the block then returns idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("block stayed busy after done");

	// the residue is fully known on every result beat
	a_res_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(residue))
		else $error("unknown residue on result beat");

endmodule

bind modular_exponentiation modexp_chk #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_modexp_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.residue (residue)
);

`default_nettype wire

// ===== tb/modexp_checker.sv =====
`timescale 1ns / 1ps

// watches the command, result and modulus ports, predicts every residue and
// compares each result beat with the oldest prediction
module modexp_checker #(
	parameter int W = 31
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic         busy,
	input  logic [W-1:0] base_value,
	input  logic [W-1:0] power,
	input  logic         done,
	input  logic [W-1:0] residue,
	input  logic         modulus_we,
	input  logic [W-1:0] modulus_wdata,
	output int           pending_residues,
	output int           fail_count
);

	logic [W-1:0] modulus_shadow;
	logic [W-1:0] residue_q[$];

	// right-to-left square and multiply, every product reduced by the modulus
	function automatic logic [W-1:0] pow_mod(logic [W-1:0] b, logic [W-1:0] e,
			logic [W-1:0] m);
		logic [63:0] sq;
		logic [63:0] acc;
		logic [63:0] mm;
		mm = 64'(m);
		// a modulus below two always gives zero
		if (mm < 64'd2)
			return '0;
		sq = 64'(b) % mm;
		acc = 64'd1;
		for (int i = 0; i < W; i++) begin
			if (e[i])
				acc = (acc * sq) % mm;
			sq = (sq * sq) % mm;
		end
		return acc[W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [W-1:0] want;
		if (!arst_n) begin
			modulus_shadow = W'(2);
			residue_q.delete();
			pending_residues <= 0;
			fail_count = 0;
		end else begin
			// result beat: compare with the oldest prediction
			if (done) begin
				if (residue_q.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, actual residue %0d",
						$time, residue);
					fail_count++;
				end else begin
					want = residue_q.pop_front();
					if (residue !== want) begin
						$display("%0t: residue mismatch, expected %0d, actual %0d",
							$time, want, residue);
						fail_count++;
					end
				end
			end
			// command beat: predict with the modulus in force
			if (start && !busy)
				residue_q.insert(residue_q.size(),
					pow_mod(base_value, power, modulus_shadow));
			// modulus write
			if (modulus_we)
				modulus_shadow = modulus_wdata;
			pending_residues <= residue_q.size();
		end
	end

endmodule

// ===== tb/modular_exponentiation_tb.sv =====
`timescale 1ns / 1ps

module modular_exponentiation_tb;

	localparam int W = 31;
	localparam int TOTAL_ITEMS = 290;
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam logic [W-1:0] OPND_MAX = '1;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         start = 1'b0;
	logic [W-1:0] base_value = '0;
	logic [W-1:0] power = '0;
	logic         modulus_we = 1'b0;
	logic [W-1:0] modulus_wdata = '0;
	logic         busy;
	logic         done;
	logic [W-1:0] residue;
	int           pending_residues;
	int           fail_count;
	int           cycle_cnt = 0;
	int           issued = 0;
	bit           burst = 1'b0;

	modular_exponentiation #(
		.OPERAND_WIDTH(W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.base_value(base_value),
		.power(power),
		.busy(busy),
		.done(done),
		.residue(residue),
		.modulus_we(modulus_we),
		.modulus_wdata(modulus_wdata)
	);

	modexp_checker #(
		.W(W)
	) chk (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.base_value(base_value),
		.power(power),
		.done(done),
		.residue(residue),
		.modulus_we(modulus_we),
		.modulus_wdata(modulus_wdata),
		.pending_residues(pending_residues),
		.fail_count(fail_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run-away guard
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// mostly short gaps, a few long ones, none in a burst phase
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 40)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(20, 150);
	endfunction

	function automatic logic [W-1:0] rand_base(logic [W-1:0] m);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return m;
			2: return m - 1'b1;
			3: return W'($urandom_range(0, 15));
			4: return OPND_MAX;
			default: return W'($urandom);
		endcase
	endfunction

	function automatic logic [W-1:0] rand_power();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return W'($urandom_range(1, 8));
			2: return OPND_MAX;
			default: return W'($urandom);
		endcase
	endfunction

	function automatic logic [W-1:0] rand_modulus();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return W'($urandom_range(0, 1));
		if (r == 1)
			return OPND_MAX;
		if (r == 2)
			return W'($urandom_range(2, 16));
		if (r < 5)
			return W'($urandom_range(2, 4095));
		return W'($urandom);
	endfunction

	// one command beat, then an optional gap with start low
	task automatic issue_cmd(input logic [W-1:0] b, input logic [W-1:0] e);
		int gap;
		base_value <= b;
		power <= e;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		issued++;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drain every outstanding result, then write the modulus
	task automatic load_modulus(input logic [W-1:0] m);
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_residues != 0 || busy);
		modulus_we <= 1'b1;
		modulus_wdata <= m;
		@(posedge clk);
		modulus_we <= 1'b0;
	endtask

	initial begin
		logic [W-1:0] m;
		int n;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset modulus of two, zero exponent and all-ones operands
		issue_cmd('0, '0);
		issue_cmd(W'(1), OPND_MAX);
		issue_cmd(OPND_MAX, OPND_MAX);
		issue_cmd(OPND_MAX, '0);

		// modulus below two gives zero, even for a zero exponent
		load_modulus('0);
		issue_cmd(W'(5), W'(3));
		issue_cmd('0, '0);
		load_modulus(W'(1));
		issue_cmd(W'(7), '0);
		issue_cmd(OPND_MAX, OPND_MAX);

		// largest modulus: base reducing to zero, full-width operands
		load_modulus(OPND_MAX);
		issue_cmd(OPND_MAX, OPND_MAX);
		issue_cmd(OPND_MAX - 1'b1, W'(2));
		issue_cmd(W'(2), W'(30));
		issue_cmd(W'(3), OPND_MAX);
		issue_cmd('0, '0);
		issue_cmd('0, W'(5));
		issue_cmd(OPND_MAX - 1'b1, OPND_MAX);

		// small modulus
		load_modulus(W'(3));
		issue_cmd(OPND_MAX, OPND_MAX);
		issue_cmd(W'(3), W'(1));

		// random phases, each under its own modulus
		while (issued < TOTAL_ITEMS) begin
			m = rand_modulus();
			load_modulus(m);
			burst = ($urandom_range(0, 3) == 0);
			n = $urandom_range(15, 35);
			repeat (n) issue_cmd(rand_base(m), rand_power());
		end

		// drain and let the block settle
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_residues != 0 || busy);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/modexp_pkg.sv
hdl/modular_exponentiation.sv
hdl/modexp_chk.sv
tb/modexp_checker.sv
tb/modular_exponentiation_tb.sv
